// ----- hdl/awls_pkg.sv -----
// Shared types, constants and helper functions for the window level statistics unit.
// No dependencies; every other file imports this package.
package awls_pkg;

	// Field widths
	localparam int RAW_W = 16;
	localparam int LVL_W = 11;
	localparam int SUM_W = 34;
	localparam int CNT_W = 25;

	// Window length at which all counters stop
	localparam int unsigned MAX_WINDOW = 32'd16777216;
	localparam int unsigned CNT_FIELD_MAX = (32'd1 << CNT_W) - 32'd1;
	localparam int unsigned CNT_CAP_I = (MAX_WINDOW < CNT_FIELD_MAX) ? MAX_WINDOW : CNT_FIELD_MAX;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);

	// Level constants
	localparam logic [LVL_W-1:0] FS_TEN = LVL_W'(11'h400);
	localparam logic [LVL_W-1:0] FS_EIGHT = LVL_W'(11'h100);
	localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);
	localparam int TEN_SHIFT = 6;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MODE = 1'b0;

	// Configuration state handed to the datapath
	typedef struct packed {
		logic ten_bit_mode;
		logic wr_valid;
		logic wr_mode;
	} awls_cfg_t;

	// Full-scale level of a mode
	function automatic logic [LVL_W-1:0] full_scale(input logic ten_bit);
		return ten_bit ? FS_TEN : FS_EIGHT;
	endfunction

	// Offset level of a raw word in a mode
	function automatic logic [LVL_W-1:0] level_of(input logic [RAW_W-1:0] raw,
		input logic ten_bit);
		logic [LVL_W-1:0] base;
		if (ten_bit) begin
			base = LVL_W'(raw >> TEN_SHIFT);
		end else begin
			base = LVL_W'(raw[7:0]);
		end
		return base + LVL_ONE;
	endfunction

	// Saturating sum; the cap is all ones so a carry out means overflow
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
		input logic [LVL_W-1:0] v);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + (SUM_W + 1)'(v);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	// Saturating counter step
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c >= CNT_CAP) ? CNT_CAP : c + CNT_W'(1);
	endfunction

endpackage

// ----- hdl/awls_sample_if.sv -----
// Input channel of the window level statistics unit: one raw sample per item.
// Depends on awls_pkg for field widths.
interface awls_sample_if;
	import awls_pkg::*;

	logic valid;
	logic ready;
	logic [RAW_W-1:0] raw_sample;
	logic window_end;

	modport source(output valid, output raw_sample, output window_end, input ready);
	modport sink(input valid, input raw_sample, input window_end, output ready);
endinterface

// ----- hdl/awls_result_if.sv -----
// Output channel of the window level statistics unit: one statistics record per item.
// Depends on awls_pkg for field widths.
interface awls_result_if;
	import awls_pkg::*;

	logic valid;
	logic ready;
	logic [LVL_W-1:0] min_level;
	logic [LVL_W-1:0] max_level;
	logic [SUM_W-1:0] total_sum;
	logic [SUM_W-1:0] below_mid_sum;
	logic [CNT_W-1:0] below_mid_count;
	logic [SUM_W-1:0] above_mid_sum;
	logic [CNT_W-1:0] above_mid_count;
	logic [CNT_W-1:0] clip_low_count;
	logic [CNT_W-1:0] clip_high_count;
	logic [CNT_W-1:0] window_samples;

	modport source(output valid, output min_level, output max_level, output total_sum,
		output below_mid_sum, output below_mid_count, output above_mid_sum,
		output above_mid_count, output clip_low_count, output clip_high_count,
		output window_samples, input ready);
	modport sink(input valid, input min_level, input max_level, input total_sum,
		input below_mid_sum, input below_mid_count, input above_mid_sum,
		input above_mid_count, input clip_low_count, input clip_high_count,
		input window_samples, output ready);
endinterface

// ----- hdl/adc_window_level_stats_unit.sv -----
// Window level statistics unit: min, max, sums, counts and clip counts per sample window.
// A sample is registered in the input register, then folded into the accumulators; the
// result register takes the closing sample's statistics. Throughput: one sample per cycle
// outside stalls; it stalls only when a result waits and another window ends.
// Reset (arst_n low, asynchronous): accumulators cleared, mode 8-bit, no item held.
// Depends on awls_pkg, awls_sample_if, awls_result_if, awls_cfg and awls_accum.
module adc_window_level_stats_unit
	import awls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	awls_sample_if.sink           sample,
	awls_result_if.source         result
);

	awls_cfg_t cfg;

	// Register block
	awls_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Datapath
	awls_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);

	// A window always holds at least one sample, so min never exceeds max
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.min_level <= result.max_level))
		else $error("min level above max level");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.window_samples != '0))
		else $error("empty window reported");

	// Below and above counts split the window until the counters saturate
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.window_samples < CNT_CAP)) |->
		(({1'b0, result.below_mid_count} + {1'b0, result.above_mid_count}) ==
		{1'b0, result.window_samples}))
		else $error("mid-scale split does not match sample count");

endmodule

// ----- hdl/awls_cfg.sv -----
// APB-style register block holding the sample mode bit.
// Depends on awls_pkg for the register map and the configuration struct.
module awls_cfg
	import awls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output awls_cfg_t             cfg
);

	logic mode_q;
	logic wr_mode_reg;

	assign pready = 1'b1;
	assign wr_mode_reg = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);

	// Hold the mode bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (wr_mode_reg) begin
			mode_q <= pwdata[0];
		end
	end

	// Read back the selected register
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MODE) begin
			prdata = APB_DATA_W'(mode_q);
		end
	end

	assign cfg.ten_bit_mode = mode_q;
	assign cfg.wr_valid = wr_mode_reg;
	assign cfg.wr_mode = pwdata[0];

endmodule

// ----- hdl/awls_accum.sv -----
// Sample input register, window accumulators and result register.
// Depends on awls_pkg and the awls_sample_if / awls_result_if channels.
module awls_accum
	import awls_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  awls_cfg_t     cfg,
	awls_sample_if.sink   sample,
	awls_result_if.source result
);

	// Input register
	logic             valid_s1;
	logic [RAW_W-1:0] raw_s1;
	logic             last_s1;

	// Window accumulators
	logic [LVL_W-1:0] run_min_q, run_max_q;
	logic [SUM_W-1:0] acc_total_q, acc_below_q, acc_above_q;
	logic [CNT_W-1:0] cnt_below_q, cnt_above_q, cnt_clip_low_q, cnt_clip_high_q;
	logic [CNT_W-1:0] cnt_samples_q;

	// Next values
	logic [LVL_W-1:0] lvl, fs, mid;
	logic [LVL_W-1:0] run_min_d, run_max_d;
	logic [SUM_W-1:0] acc_total_d, acc_below_d, acc_above_d;
	logic [CNT_W-1:0] cnt_below_d, cnt_above_d, cnt_clip_low_d, cnt_clip_high_d;
	logic [CNT_W-1:0] cnt_samples_d;

	// Result register
	logic out_valid_q;
	logic advance;

	// Advance unless a closing item meets a result that is still waiting
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	// Capture the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			raw_s1 <= sample.raw_sample;
			last_s1 <= sample.window_end;
		end
	end

	// Decode the level and fold it into the window statistics
	always_comb begin
		fs = full_scale(cfg.ten_bit_mode);
		mid = fs >> 1;
		lvl = level_of(raw_s1, cfg.ten_bit_mode);
		run_min_d = (lvl < run_min_q) ? lvl : run_min_q;
		run_max_d = (lvl > run_max_q) ? lvl : run_max_q;
		acc_total_d = sat_add(acc_total_q, lvl);
		acc_below_d = acc_below_q;
		acc_above_d = acc_above_q;
		cnt_below_d = cnt_below_q;
		cnt_above_d = cnt_above_q;
		if (lvl < mid) begin
			acc_below_d = sat_add(acc_below_q, lvl);
			cnt_below_d = sat_inc(cnt_below_q);
		end else begin
			acc_above_d = sat_add(acc_above_q, lvl);
			cnt_above_d = sat_inc(cnt_above_q);
		end
		cnt_clip_low_d = (lvl == LVL_ONE) ? sat_inc(cnt_clip_low_q) : cnt_clip_low_q;
		cnt_clip_high_d = (lvl == fs) ? sat_inc(cnt_clip_high_q) : cnt_clip_high_q;
		cnt_samples_d = sat_inc(cnt_samples_q);
	end

	// Update accumulators; clear them after the closing item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= full_scale(1'b0);
			run_max_q <= LVL_ONE;
			acc_total_q <= '0;
			acc_below_q <= '0;
			acc_above_q <= '0;
			cnt_below_q <= '0;
			cnt_above_q <= '0;
			cnt_clip_low_q <= '0;
			cnt_clip_high_q <= '0;
			cnt_samples_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				run_min_q <= fs;
				run_max_q <= LVL_ONE;
				acc_total_q <= '0;
				acc_below_q <= '0;
				acc_above_q <= '0;
				cnt_below_q <= '0;
				cnt_above_q <= '0;
				cnt_clip_low_q <= '0;
				cnt_clip_high_q <= '0;
				cnt_samples_q <= '0;
			end else begin
				run_min_q <= run_min_d;
				run_max_q <= run_max_d;
				acc_total_q <= acc_total_d;
				acc_below_q <= acc_below_d;
				acc_above_q <= acc_above_d;
				cnt_below_q <= cnt_below_d;
				cnt_above_q <= cnt_above_d;
				cnt_clip_low_q <= cnt_clip_low_d;
				cnt_clip_high_q <= cnt_clip_high_d;
				cnt_samples_q <= cnt_samples_d;
			end
		end else if (cfg.wr_valid && (cnt_samples_q == '0)) begin
			// Empty window: minimum restarts at the new full scale
			run_min_q <= full_scale(cfg.wr_mode);
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result.min_level <= run_min_d;
			result.max_level <= run_max_d;
			result.total_sum <= acc_total_d;
			result.below_mid_sum <= acc_below_d;
			result.below_mid_count <= cnt_below_d;
			result.above_mid_sum <= acc_above_d;
			result.above_mid_count <= cnt_above_d;
			result.clip_low_count <= cnt_clip_low_d;
			result.clip_high_count <= cnt_clip_high_d;
			result.window_samples <= cnt_samples_d;
		end
	end

	assign result.valid = out_valid_q;

endmodule

// ----- tb/sv/awls_stats_checker.sv -----
`timescale 1ns / 100ps
// Checker for the window level statistics unit: watches the sample, result and register
// channels, predicts each window's statistics and compares them. Depends on awls_pkg and
// the two channel interfaces.
module awls_stats_checker
	import awls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	awls_sample_if                samp_ch,
	awls_result_if                res_ch,
	output int                    mismatches,
	output int                    pending,
	output int                    windows_done,
	output int                    samples_taken
);

	localparam logic [SUM_W-1:0] SUM_CAP = '1;
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [LVL_W-1:0] min_level;
		logic [LVL_W-1:0] max_level;
		logic [SUM_W-1:0] total_sum;
		logic [SUM_W-1:0] below_mid_sum;
		logic [CNT_W-1:0] below_mid_count;
		logic [SUM_W-1:0] above_mid_sum;
		logic [CNT_W-1:0] above_mid_count;
		logic [CNT_W-1:0] clip_low_count;
		logic [CNT_W-1:0] clip_high_count;
		logic [CNT_W-1:0] window_samples;
	} window_stats_t;

	logic ten_mode;
	window_stats_t running;
	window_stats_t expected_stats[$];
	window_stats_t seen;
	window_stats_t want;

	// Print one line per mismatch, up to a cap, and count them all
	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] exp_val);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("%0t: window stats mismatch on %s: got %0d, want %0d",
				$time, what, got, exp_val);
		end
	endtask

	function automatic logic [SUM_W-1:0] sum_capped(input logic [SUM_W-1:0] acc,
		input logic [LVL_W-1:0] lvl);
		logic [SUM_W:0] wide;
		wide = {1'b0, acc} + {{(SUM_W + 1 - LVL_W){1'b0}}, lvl};
		return (wide > {1'b0, SUM_CAP}) ? SUM_CAP : wide[SUM_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] count_capped(input logic [CNT_W-1:0] c);
		return (c >= CNT_CAP) ? CNT_CAP : c + CNT_W'(1);
	endfunction

	// Start a fresh window in the current mode
	task automatic clear_running();
		running = '0;
		running.min_level = ten_mode ? FS_TEN : FS_EIGHT;
		running.max_level = LVL_W'(1);
	endtask

	// Fold one sample into the window; close it on the last flag
	task automatic fold_sample(input logic [RAW_W-1:0] raw, input logic last);
		logic [LVL_W-1:0] lvl;
		logic [LVL_W-1:0] top;
		logic [LVL_W-1:0] mid;
		top = ten_mode ? FS_TEN : FS_EIGHT;
		mid = top >> 1;
		lvl = ten_mode ? {1'b0, raw[15:6]} + LVL_W'(1) : {3'b000, raw[7:0]} + LVL_W'(1);
		running.total_sum = sum_capped(running.total_sum, lvl);
		if (lvl < running.min_level) running.min_level = lvl;
		if (lvl > running.max_level) running.max_level = lvl;
		if (lvl < mid) begin
			running.below_mid_sum = sum_capped(running.below_mid_sum, lvl);
			running.below_mid_count = count_capped(running.below_mid_count);
		end else begin
			running.above_mid_sum = sum_capped(running.above_mid_sum, lvl);
			running.above_mid_count = count_capped(running.above_mid_count);
		end
		if (lvl == LVL_W'(1)) running.clip_low_count = count_capped(running.clip_low_count);
		if (lvl == top) running.clip_high_count = count_capped(running.clip_high_count);
		running.window_samples = count_capped(running.window_samples);
		if (last) begin
			expected_stats.push_back(running);
			clear_running();
		end
	endtask

	task automatic check_stats(input window_stats_t got, input window_stats_t exp_s);
		if (got.min_level !== exp_s.min_level)
			report_mismatch("min_level", 64'(got.min_level), 64'(exp_s.min_level));
		if (got.max_level !== exp_s.max_level)
			report_mismatch("max_level", 64'(got.max_level), 64'(exp_s.max_level));
		if (got.total_sum !== exp_s.total_sum)
			report_mismatch("total_sum", 64'(got.total_sum), 64'(exp_s.total_sum));
		if (got.below_mid_sum !== exp_s.below_mid_sum)
			report_mismatch("below_mid_sum", 64'(got.below_mid_sum),
				64'(exp_s.below_mid_sum));
		if (got.below_mid_count !== exp_s.below_mid_count)
			report_mismatch("below_mid_count", 64'(got.below_mid_count),
				64'(exp_s.below_mid_count));
		if (got.above_mid_sum !== exp_s.above_mid_sum)
			report_mismatch("above_mid_sum", 64'(got.above_mid_sum),
				64'(exp_s.above_mid_sum));
		if (got.above_mid_count !== exp_s.above_mid_count)
			report_mismatch("above_mid_count", 64'(got.above_mid_count),
				64'(exp_s.above_mid_count));
		if (got.clip_low_count !== exp_s.clip_low_count)
			report_mismatch("clip_low_count", 64'(got.clip_low_count),
				64'(exp_s.clip_low_count));
		if (got.clip_high_count !== exp_s.clip_high_count)
			report_mismatch("clip_high_count", 64'(got.clip_high_count),
				64'(exp_s.clip_high_count));
		if (got.window_samples !== exp_s.window_samples)
			report_mismatch("window_samples", 64'(got.window_samples),
				64'(exp_s.window_samples));
	endtask

	// Observe all three channels at each rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			ten_mode = 1'b0;
			clear_running();
			expected_stats.delete();
			mismatches = 0;
			windows_done = 0;
			samples_taken = 0;
		end else begin
			// Compare a delivered item with the oldest expectation
			if (res_ch.valid && res_ch.ready) begin
				windows_done++;
				seen = '{min_level: res_ch.min_level, max_level: res_ch.max_level,
					total_sum: res_ch.total_sum, below_mid_sum: res_ch.below_mid_sum,
					below_mid_count: res_ch.below_mid_count,
					above_mid_sum: res_ch.above_mid_sum,
					above_mid_count: res_ch.above_mid_count,
					clip_low_count: res_ch.clip_low_count,
					clip_high_count: res_ch.clip_high_count,
					window_samples: res_ch.window_samples};
				if (expected_stats.size() == 0) begin
					report_mismatch("result item with nothing pending", 64'(1), 64'(0));
				end else begin
					want = expected_stats.pop_front();
					check_stats(seen, want);
				end
			end
			// Predict from each accepted sample
			if (samp_ch.valid && samp_ch.ready) begin
				samples_taken++;
				fold_sample(samp_ch.raw_sample, samp_ch.window_end);
			end
			// Track mode writes; the block decodes only paddr[2] and ignores writes with it set
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00 &&
				(paddr >> 2) == APB_ADDR_W'(REG_MODE)) begin
				ten_mode = pwdata[0];
				if (running.window_samples == '0)
					running.min_level = ten_mode ? FS_TEN : FS_EIGHT;
			end
		end
		pending = expected_stats.size();
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Top of the window level statistics testbench: clock, reset, sample and register
// stimulus, result back-pressure and the verdict. Depends on awls_pkg, the channel
// interfaces, adc_window_level_stats_unit and awls_stats_checker.
module tb
	import awls_pkg::*;
();

	localparam int IDLE_PCT = 32;
	localparam int SETTLE = 6;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_AT = 60;
	localparam int HOLD_CYCLES = 200;
	localparam int CALM_FROM = 100;
	localparam int CALM_TO = 130;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 117;
	localparam int BURST_FROM = 250;
	localparam int BURST_TO = 380;
	localparam int PAUSE_AT = 470;
	localparam logic [APB_ADDR_W-1:0] MODE_ADDR = APB_ADDR_W'(4 * int'(REG_MODE));
	// First address past the only register
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = MODE_ADDR + APB_ADDR_W'(4);

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	int mismatches;
	int pending;
	int windows_done;
	int samples_taken;
	int quiet_cycles = 0;
	int mode_writes = 0;
	logic sender_gaps = 1'b1;

	awls_sample_if sample_ch();
	awls_result_if result_ch();

	adc_window_level_stats_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample(sample_ch),
		.result(result_ch)
	);

	awls_stats_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.samp_ch(sample_ch),
		.res_ch(result_ch),
		.mismatches(mismatches),
		.pending(pending),
		.windows_done(windows_done),
		.samples_taken(samples_taken)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offer one sample from a falling edge, hold it until taken, then drop valid
	task automatic push_sample(input logic [RAW_W-1:0] raw, input logic last);
		while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid = 1'b0;
			@(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.raw_sample = raw;
		sample_ch.window_end = last;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
		sample_ch.valid = 1'b0;
	endtask

	// Setup then access phase; the write lands at the access edge
	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (addr == MODE_ADDR) mode_writes++;
	endtask

	// Wait for every expected item, then let the pipeline fold trailing samples
	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [RAW_W-1:0] pick_raw();
		logic [RAW_W-1:0] corners [6];
		corners = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'hFFC0, 16'h003F};
		case ($urandom_range(7))
			0: begin
				return corners[3'($urandom_range(5))];
			end
			1: begin
				// around 8-bit mid-scale, noise in the upper byte
				return {8'($urandom_range(255)), 8'h7E + 8'($urandom_range(1))};
			end
			2: begin
				// around 10-bit mid-scale, noise in the dropped bits
				return {10'h1FE + 10'($urandom_range(1)), 6'($urandom_range(63))};
			end
			3: begin
				// 8-bit clip levels with noise in the upper byte
				return {8'($urandom_range(255)), {8{1'($urandom_range(1))}}};
			end
			default: begin
				return RAW_W'($urandom_range(65535));
			end
		endcase
	endfunction

	// Stall the result side at random, with one long hold-off and one calm stretch
	initial begin : result_drain
		int hold_cnt;
		logic held;
		held = 1'b0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && windows_done >= HOLD_AT) begin
				held = 1'b1;
				result_ch.ready = 1'b0;
				hold_cnt = 0;
				while (hold_cnt < HOLD_CYCLES) begin
					@(negedge clk);
					hold_cnt++;
				end
			end
			result_ch.ready = (windows_done >= CALM_FROM && windows_done < CALM_TO) ||
				($urandom_range(99) >= IDLE_PCT);
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles, %0d items pending", quiet_cycles, pending);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int rand_sent;
		int end_pct [PHASES];
		logic phase_mode [PHASES];
		end_pct = '{25, 8, 40, 15, 60, 4};
		phase_mode = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
		rand_sent = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_sample = '0;
		sample_ch.window_end = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 8-bit mode after reset: clip levels, ignored upper byte, both sides of mid
		push_sample(16'h0000, 1'b0);
		push_sample(16'h00FF, 1'b0);
		push_sample(16'hFF00, 1'b0);
		push_sample(16'h007E, 1'b0);
		push_sample(16'h007F, 1'b0);
		push_sample(16'hAA55, 1'b1);
		// single-sample windows, one at full scale
		push_sample(16'h1234, 1'b1);
		push_sample(16'h00FF, 1'b1);

		// mode change on an empty window resets the minimum to the new full scale
		wait_drained();
		write_reg(MODE_ADDR, 32'h0000_0001);
		push_sample(16'h0000, 1'b0);
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'h003F, 1'b0);
		push_sample(16'h7F80, 1'b0);
		push_sample(16'h7FC0, 1'b0);
		push_sample(16'h8000, 1'b1);
		push_sample(16'hFFC0, 1'b1);

		// mode change inside an open window keeps the accumulators and minimum
		push_sample(16'h1000, 1'b0);
		push_sample(16'h0040, 1'b0);
		wait_drained();
		write_reg(MODE_ADDR, 32'h0000_0000);
		push_sample(16'h00FF, 1'b0);
		push_sample(16'h0100, 1'b1);

		// a write past the register map must leave the mode alone
		wait_drained();
		write_reg(SPARE_ADDR, 32'h0000_0001);
		push_sample(16'h0080, 1'b1);

		// random phases, each under its own mode and window length
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_reg(MODE_ADDR, {31'($urandom), phase_mode[3'(ph)]});
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				sender_gaps = !(rand_sent >= BURST_FROM && rand_sent < BURST_TO);
				if (rand_sent == PAUSE_AT) begin
					while (pending != 0) @(negedge clk);
				end
				push_sample(pick_raw(), $urandom_range(99) < end_pct[3'(ph)]);
				rand_sent++;
			end
		end
		// close whatever window is still open
		push_sample(pick_raw(), 1'b1);

		while (pending != 0) @(negedge clk);
		repeat (SETTLE * 2) @(negedge clk);
		$display("covered %0d samples in %0d windows, %0d mode writes in 8- and 10-bit modes,",
			samples_taken, windows_done, mode_writes);
		$display("mode changes inside open windows, a stray address and a long result stall");
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/awls_pkg.sv
hdl/awls_sample_if.sv
hdl/awls_result_if.sv
hdl/awls_cfg.sv
hdl/awls_accum.sv
hdl/adc_window_level_stats_unit.sv
tb/sv/awls_stats_checker.sv
tb/sv/tb.sv
